@@ hw/rtl/ftmt_pkg.sv @@
`default_nettype none
package ftmt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [15:0] NO_CHANNEL = 16'hFFFF;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CREATE = 1'b1;

	typedef enum logic [1:0] {
		ST_MATCH = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] service_type;
		logic [15:0] direction;
		logic [15:0] new_channel_id;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] channel_id;
	} rsp_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] service_type;
		logic [15:0] direction;
		logic [15:0] channel_id;
	} entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/ftmt_entry_ram.sv @@
`default_nettype none
module ftmt_entry_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [ftmt_pkg::IDX_W-1:0] waddr,
	input  wire ftmt_pkg::entry_t          wdata,
	input  wire logic                      re,
	input  wire logic [ftmt_pkg::IDX_W-1:0] raddr,
	output      ftmt_pkg::entry_t          rdata
);
	import ftmt_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/flow_tuple_match_table.sv @@
// done rises after the scan over the n stored entries (n = 0..64) ends; a hit ends the scan early
// one request at a time: start is taken only in idle, and busy is high while a request is handled
// the scan reads one entry per cycle from the entry ram, compare in the cycle after the read
// the receiver cannot stall: done is a single-cycle strobe
// reset clears the entry count (table empty); ram contents are left as they are
`default_nettype none
module flow_tuple_match_table (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire ftmt_pkg::req_t req,
	output      logic           done,
	output      ftmt_pkg::rsp_t rsp
);
	import ftmt_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic             vld_s1;
	logic             done_q;
	rsp_t             rsp_q;

	logic             rd_en;
	entry_t           rd_data;
	logic             wr_en;
	entry_t           wr_data;
	logic             hit;
	logic             finish;
	logic             present;
	logic             room;
	rsp_t             rsp_d;

	assign rd_en = (state_q == S_SCAN) && (issue_q != count_q);

	assign hit = vld_s1
		&& (rd_data.src_addr == req_q.src_addr)
		&& (rd_data.dst_addr == req_q.dst_addr)
		&& (rd_data.service_type == req_q.service_type)
		&& (rd_data.direction == req_q.direction);

	assign finish  = (state_q == S_SCAN) && (hit || (issue_q == count_q && !vld_s1)
		|| (issue_q == count_q && vld_s1 && !hit));
	assign present = hit && (rd_data.channel_id != NO_CHANNEL);
	assign room    = (count_q != CNT_W'(TABLE_DEPTH));

	always_comb begin
		rsp_d.status     = ST_MISS;
		rsp_d.channel_id = NO_CHANNEL;
		wr_en            = 1'b0;
		if (present) begin
			rsp_d.status     = ST_MATCH;
			rsp_d.channel_id = rd_data.channel_id;
		end else if (req_q.cmd == CMD_CREATE) begin
			if (room) begin
				wr_en = finish;
			end else begin
				rsp_d.status = ST_FULL;
			end
		end
	end

	assign wr_data.src_addr     = req_q.src_addr;
	assign wr_data.dst_addr     = req_q.dst_addr;
	assign wr_data.service_type = req_q.service_type;
	assign wr_data.direction    = req_q.direction;
	assign wr_data.channel_id   = req_q.new_channel_id;

	ftmt_entry_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			rsp_q   <= '{status: ST_MISS, channel_id: NO_CHANNEL};
		end else begin
			done_q <= 1'b0;
			vld_s1 <= rd_en && !finish;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						issue_q <= '0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						rsp_q   <= rsp_d;
						if (wr_en) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire
